FILE: rtl/imu_bias_calibrate_and_scale_defines.svh
// Assertion macros shared by the IMU bias calibration RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IMU_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH

// same-cycle implication
`define IBCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define IBCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/ibcs_pkg.sv
// Types and constants for the IMU bias calibration and scaling block.
// No dependencies.
package ibcs_pkg;

   localparam int RAW_W  = 16;
   localparam int ACC_W  = 23;
   localparam int GYR_W  = 29;
   localparam int TMP_W  = 17;
   localparam int PCT_W  = 7;
   localparam int STAT_W = 2;
   localparam int SENS_W = 11;

   // register indexes
   localparam logic [1:0] REG_GYRO_RANGE  = 2'd0;
   localparam logic [1:0] REG_ACCEL_RANGE = 2'd1;
   localparam logic [1:0] REG_CALIB_COUNT = 2'd2;

   // calibration status codes
   localparam logic [STAT_W-1:0] ST_RUN  = 2'd0;
   localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FAIL = 2'd2;

   localparam logic CMD_MEASURE   = 1'b0;
   localparam logic CMD_CALIB     = 1'b1;
   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_PROGRESS = 1'b1;

   // per-item operation codes (one divide each)
   localparam logic [2:0] OP_AX  = 3'd0;
   localparam logic [2:0] OP_AY  = 3'd1;
   localparam logic [2:0] OP_AZ  = 3'd2;
   localparam logic [2:0] OP_TMP = 3'd3;
   localparam logic [2:0] OP_GX  = 3'd4;
   localparam logic [2:0] OP_GY  = 3'd5;
   localparam logic [2:0] OP_GZ  = 3'd6;
   localparam logic [2:0] OP_PCT = 3'd7;

   // temp * 256 = (raw * 25600 + 3653 * 87040) / 34000
   localparam int TEMP_MUL = 25600;
   localparam int TEMP_OFS = 317957120;
   localparam int TEMP_DEN = 34000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // gyro sensitivity in tenths of an LSB per deg/s
   function automatic logic [SENS_W-1:0] gyro_sens10(input logic [1:0] r);
      logic [SENS_W-1:0] s;
      unique case (r)
         2'd0: s = 11'd1310;
         2'd1: s = 11'd655;
         2'd2: s = 11'd328;
         2'd3: s = 11'd164;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/ibcs_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ibcs_pkg and the shared assertion header.
`include "imu_bias_calibrate_and_scale_defines.svh"
module ibcs_serial_div #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 31
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output ibcs_pkg::div_stat_type     stat,
   output logic [NUM_W-1:0]           quot
);
   import ibcs_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   // one shift-and-subtract step
   always_comb begin
      trial   = {rem_ff, q_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

   `IBCS_ASSERT_IMP(a_den_nonzero, clock, reset, busy_ff, den_ff != '0)
   `IBCS_ASSERT_IMP(a_rem_below_den, clock, reset, busy_ff, rem_ff < den_ff)
   `IBCS_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff && !busy_ff)

endmodule

FILE: rtl/imu_bias_calibrate_and_scale.sv
// IMU bias calibration and scaling, top level.
// A measure item runs seven divides, a calibration item one, and a calibration item that
// ends a good run seven: the percent divide, then six bias divides.
// One item at a time; the next is taken in the cycle after the result is registered, later
// while a held result blocks the output stage. All divides share one bit-serial divider.
// Reset (synchronous, active high) clears control, run and output state, not the operands.
`include "imu_bias_calibrate_and_scale_defines.svh"
module imu_bias_calibrate_and_scale #(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   // req_tdata: accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
   //            gyro_x_raw, gyro_y_raw, gyro_z_raw (16 bits each)
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,
   // req_tuser: cmd, sample_ok
   input  logic [1:0]    req_tuser,
   // rsp_tdata: accel_x_g, accel_y_g, accel_z_g (23), temp_c (17),
   //            gyro_x_dps, gyro_y_dps, gyro_z_dps (29), progress_pct (7),
   //            calib_status (2), calibrated (1), one zero pad bit
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [183:0]  rsp_tdata,
   // rsp_tuser: result_kind
   output logic          rsp_tuser,
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [15:0]   csr_wdata
);
   import ibcs_pkg::*;

   localparam int NW  = 36 + FRAC_BITS;
   localparam int DW  = 15 + COUNT_BITS;
   localparam int NSW = NW + 1;
   localparam int VW  = NW + 2;
   localparam int CB  = COUNT_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // configuration
   logic [1:0]  gyro_range_ff, accel_range_ff;
   logic [15:0] calib_count_ff;

   // control and run state
   logic [2:0]  state_ff, op_ff;
   logic        cmd_ff, end_ff, pass_ff, cal_ff;
   logic [STAT_W-1:0] status_ff;
   logic [CB-1:0] idx_ff, pidx_ff, vcnt_ff;
   logic signed [RAW_W-1:0] chan_ff [7];
   logic signed [31:0] sum_ff [6];
   logic signed [ACC_W-1:0] abias_ff [3];
   logic signed [GYR_W-1:0] gbias_ff [3];
   logic signed [GYR_W-1:0] res_ff [7];
   logic [PCT_W-1:0] pct_ff;

   // divide operands
   logic signed [NSW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic          neg_ff, round_ff;
   logic [NW-1:0] mag;
   logic          div_start;
   div_stat_type  div_stat;
   logic [NW-1:0] quot;

   // output register
   logic          rsp_valid_ff, rsp_kind_ff;
   logic [183:0]  rsp_data_ff;

   // accept-time helpers
   logic [CB-1:0] count_w, count_c, vnew;
   logic          run_end, run_fail;

   // post-divide helpers
   logic signed [VW-1:0] qs, sub, val, s23, s29, s17;
   logic [2:0] sidx;
   logic signed [31:0] src;
   logic [CB-1:0] vden;

   function automatic logic signed [VW-1:0] sat_to(input logic signed [VW-1:0] v,
                                                    input int bits);
      logic signed [VW-1:0] hi, lo;
      hi = (VW'(1) <<< (bits - 1)) - VW'(1);
      lo = -hi - VW'(1);
      if (v > hi) return hi;
      else if (v < lo) return lo;
      else return v;
   endfunction

   assign req_tready = (state_ff == S_IDLE);

   // run length and end-of-run test on a calibration item
   always_comb begin
      count_w  = CB'(calib_count_ff);
      count_c  = (count_w == '0) ? CB'(1) : count_w;
      vnew     = req_tuser[1] ? vcnt_ff + CB'(1) : vcnt_ff;
      run_end  = ({1'b0, idx_ff} + (CB + 1)'(1)) >= {1'b0, count_c};
      run_fail = (vnew == '0) || (vnew < (count_c >> 1));
   end

   // operands for the current operation
   always_comb begin
      sidx = (op_ff < OP_TMP) ? op_ff : op_ff - 3'd1;
      src  = (cmd_ff == CMD_MEASURE) ? 32'(chan_ff[op_ff]) : sum_ff[sidx[2:0]];
      vden = (cmd_ff == CMD_MEASURE) ? CB'(1) : vcnt_ff;
      num_in = num_ff;
      den_in = den_ff;
      unique case (op_ff)
         OP_AX, OP_AY, OP_AZ: begin
            num_in = NSW'(src) <<< FRAC_BITS;
            den_in = DW'(vden) << (4'd14 - {2'b00, accel_range_ff});
         end
         OP_TMP: begin
            num_in = NSW'(chan_ff[3]) * NSW'(TEMP_MUL) + NSW'(TEMP_OFS);
            den_in = DW'(TEMP_DEN);
         end
         OP_GX, OP_GY, OP_GZ: begin
            num_in = (NSW'(src) * NSW'(10)) <<< FRAC_BITS;
            den_in = DW'(gyro_sens10(gyro_range_ff)) * DW'(vden);
         end
         OP_PCT: begin
            num_in = NSW'(pidx_ff) * NSW'(100);
            den_in = DW'(count_c);
         end
      endcase
   end

   // magnitude plus, except for the percent, half the divisor for round to nearest
   always_comb begin
      mag = num_ff[NSW-1] ? NW'(-num_ff) : NW'(num_ff);
      mag = mag + (round_ff ? NW'(den_ff >> 1) : NW'(0));
   end
   assign div_start = (state_ff == S_PREP);

   ibcs_serial_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mag),
      .den   (den_ff),
      .stat  (div_stat),
      .quot  (quot)
   );

   // signed quotient, bias removal (1 g off calibration Z), saturation
   always_comb begin
      qs  = neg_ff ? -VW'(quot) : VW'(quot);
      sub = '0;
      if (cmd_ff == CMD_MEASURE) begin
         if (op_ff < OP_TMP) sub = VW'(abias_ff[sidx[1:0]]);
         else if (op_ff > OP_TMP && op_ff != OP_PCT) sub = VW'(gbias_ff[2'(op_ff - OP_GX)]);
      end else if (op_ff == OP_AZ) begin
         sub = VW'(1) <<< FRAC_BITS;
      end
      val = qs - sub;
      s23 = sat_to(val, ACC_W);
      s29 = sat_to(val, GYR_W);
      s17 = sat_to(val, TMP_W);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_range_ff  <= 2'd0;
         accel_range_ff <= 2'd0;
         calib_count_ff <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_GYRO_RANGE:  gyro_range_ff  <= csr_wdata[1:0];
            REG_ACCEL_RANGE: accel_range_ff <= csr_wdata[1:0];
            REG_CALIB_COUNT: calib_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand registers (payload, no reset)
   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         round_ff <= (op_ff != OP_PCT);
      end
      if (state_ff == S_PREP) neg_ff <= num_ff[NSW-1];
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < 7; i++) chan_ff[i] <= req_tdata[16*i +: 16];
      end
   end

   // sequencer, run state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_AX;
         cmd_ff       <= CMD_MEASURE;
         end_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         cal_ff       <= 1'b0;
         status_ff    <= ST_RUN;
         idx_ff       <= '0;
         pidx_ff      <= '0;
         vcnt_ff      <= '0;
         pct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= KIND_SAMPLE;
         rsp_data_ff  <= '0;
         for (int i = 0; i < 6; i++) sum_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            abias_ff[i] <= '0;
            gbias_ff[i] <= '0;
         end
         for (int i = 0; i < 7; i++) res_ff[i] <= '0;
      end else begin
         // output valid: set when a result is registered, cleared once taken
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_tuser[0];
                  state_ff <= S_LOAD;
                  if (req_tuser[0] == CMD_CALIB) begin
                     op_ff     <= OP_PCT;
                     pidx_ff   <= idx_ff;
                     vcnt_ff   <= vnew;
                     end_ff    <= run_end;
                     pass_ff   <= run_end && !run_fail;
                     status_ff <= run_end ? (run_fail ? ST_FAIL : ST_OK) : ST_RUN;
                     if (run_end && !run_fail) cal_ff <= 1'b1;
                     if (!run_end) idx_ff <= idx_ff + CB'(1);
                     if (req_tuser[1]) begin
                        sum_ff[0] <= sum_ff[0] + 32'(signed'(req_tdata[15:0]));
                        sum_ff[1] <= sum_ff[1] + 32'(signed'(req_tdata[31:16]));
                        sum_ff[2] <= sum_ff[2] + 32'(signed'(req_tdata[47:32]));
                        sum_ff[3] <= sum_ff[3] + 32'(signed'(req_tdata[79:64]));
                        sum_ff[4] <= sum_ff[4] + 32'(signed'(req_tdata[95:80]));
                        sum_ff[5] <= sum_ff[5] + 32'(signed'(req_tdata[111:96]));
                     end
                  end else begin
                     op_ff <= OP_AX;
                  end
               end
            end
            S_LOAD: state_ff <= S_PREP;
            S_PREP: state_ff <= S_WAIT;
            S_WAIT: if (div_stat.done) state_ff <= S_POST;
            S_POST: begin
               // store the result of this operation
               if (op_ff == OP_PCT) begin
                  pct_ff <= (quot > NW'(100)) ? PCT_W'(100) : quot[PCT_W-1:0];
               end else if (cmd_ff == CMD_MEASURE) begin
                  if (op_ff < OP_TMP) res_ff[op_ff] <= GYR_W'(s23);
                  else if (op_ff == OP_TMP) res_ff[op_ff] <= GYR_W'(s17);
                  else res_ff[op_ff] <= GYR_W'(s29);
               end else begin
                  if (op_ff < OP_TMP) abias_ff[sidx[1:0]] <= ACC_W'(s23);
                  else gbias_ff[2'(op_ff - OP_GX)] <= GYR_W'(s29);
               end
               // choose the next operation
               if (op_ff == OP_PCT) begin
                  if (pass_ff) begin
                     op_ff    <= OP_AX;
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else if (op_ff == OP_GZ) begin
                  state_ff <= S_OUT;
               end else if (cmd_ff == CMD_CALIB && op_ff == OP_AZ) begin
                  op_ff    <= OP_GX;
                  state_ff <= S_LOAD;
               end else begin
                  op_ff    <= op_ff + 3'd1;
                  state_ff <= S_LOAD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= S_IDLE;
                  if (cmd_ff == CMD_MEASURE) begin
                     rsp_kind_ff <= KIND_SAMPLE;
                     rsp_data_ff <= {1'b0, cal_ff, ST_RUN, PCT_W'(0),
                                     res_ff[6], res_ff[5], res_ff[4],
                                     res_ff[3][TMP_W-1:0], res_ff[2][ACC_W-1:0],
                                     res_ff[1][ACC_W-1:0], res_ff[0][ACC_W-1:0]};
                  end else begin
                     rsp_kind_ff <= KIND_PROGRESS;
                     rsp_data_ff <= {1'b0, cal_ff, status_ff, pct_ff, 173'd0};
                     if (end_ff) begin
                        idx_ff  <= '0;
                        vcnt_ff <= '0;
                        for (int i = 0; i < 6; i++) sum_ff[i] <= '0;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   `IBCS_ASSERT_NXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE)
   `IBCS_ASSERT_IMP(a_sample_no_progress, clock, reset, rsp_tvalid && rsp_tuser == KIND_SAMPLE,
                    rsp_tdata[181:173] == '0)
   `IBCS_ASSERT_IMP(a_progress_no_data, clock, reset, rsp_tvalid && rsp_tuser == KIND_PROGRESS,
                    rsp_tdata[172:0] == '0)
   `IBCS_ASSERT_IMP(a_bias_only_on_pass, clock, reset,
                    state_ff == S_POST && cmd_ff == CMD_CALIB && op_ff != OP_PCT, pass_ff)

endmodule
